[hw/rtl/touch_wake_controller_assert.svh]
// ----------------------------------------------------------------------------
// touch_wake_controller_assert.svh
// assertion macros shared by the touch wake controller rtl
// ----------------------------------------------------------------------------
`ifndef TOUCH_WAKE_CONTROLLER_ASSERT_SVH
`define TOUCH_WAKE_CONTROLLER_ASSERT_SVH

// property checked on every clock edge outside reset
`define TWC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("twc assertion failed");

// condition that must never be true outside reset
`define TWC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("twc forbidden condition seen");

`endif

[hw/rtl/twc_pkg.sv]
// ----------------------------------------------------------------------------
// twc_pkg
// types and constants of the touch wake controller
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int unsigned DelayBits   = 24;
  localparam int unsigned WindowBits  = 16;
  localparam int unsigned ElapsedBits = 16;
  localparam int unsigned BusyBits    = 11;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 24;

  localparam int unsigned LongPressMs = 500;
  localparam int unsigned KeyHoldMs   = 100;
  localparam int unsigned PressTailMs = 1000;
  localparam int unsigned BusyMax     = (1 << BusyBits) - 1;
  localparam int unsigned BusyRaw     = 2 * KeyHoldMs + PressTailMs;
  localparam int unsigned BusyLoadInt = (BusyRaw > BusyMax) ? BusyMax : BusyRaw;
  localparam int unsigned KdLimitInt  = BusyLoadInt - KeyHoldMs;

  localparam logic [BusyBits-1:0]    BusyLoad     = BusyLoadInt[BusyBits-1:0];
  localparam logic [BusyBits-1:0]    KdLimit      = KdLimitInt[BusyBits-1:0];
  localparam logic [ElapsedBits-1:0] LongPress    = LongPressMs[ElapsedBits-1:0];
  localparam logic [ElapsedBits-1:0] ElapsedMax   = '1;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_SUSPEND     = 3'd1,
    CMD_RESUME      = 3'd2,
    CMD_TOUCH       = 3'd3,
    CMD_KEY_PRESS   = 3'd4,
    CMD_KEY_RELEASE = 3'd5,
    CMD_PROX_NEAR   = 3'd6,
    CMD_PROX_FAR    = 3'd7
  } cmd_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_WAKE_ENABLE  = 3'd0,
    CFG_KEY_POWER    = 3'd1,
    CFG_KNOCK_ENABLE = 3'd2,
    CFG_KNOCK_WINDOW = 3'd3,
    CFG_OFF_DELAY    = 3'd4,
    CFG_CHARGE_DELAY = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    cmd_e cmd;
    logic charging;
  } in_word_t;

  typedef struct packed {
    logic touch_on;
    logic wake_hold;
    logic key_down;
    logic wake_busy;
    logic is_suspended;
  } out_word_t;

  typedef struct packed {
    logic                  wake_enable;
    logic                  key_power_mode;
    logic                  knock_enable;
    logic [WindowBits-1:0] knock_window_ms;
    logic [DelayBits-1:0]  off_delay_ms;
    logic [DelayBits-1:0]  charge_off_delay_ms;
  } cfg_t;

endpackage

[hw/rtl/twc_core.sv]
// ----------------------------------------------------------------------------
// twc_core
// controller state and its combinational update for one event word
// ----------------------------------------------------------------------------
module twc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  twc_pkg::in_word_t   word_i,
  input  twc_pkg::cfg_t       cfg_i,
  output twc_pkg::out_word_t  res_o
);

  logic touch_off_q, touch_off_d;
  logic hold_q, hold_d;
  logic asleep_q, asleep_d;
  logic timed_out_q, timed_out_d;
  logic near_q, near_d;
  logic armed_q, armed_d;
  logic [twc_pkg::DelayBits-1:0]   off_timer_q, off_timer_d;
  logic off_run_q, off_run_d;
  logic [twc_pkg::WindowBits-1:0]  tap_timer_q, tap_timer_d;
  logic tap_run_q, tap_run_d;
  logic [twc_pkg::ElapsedBits-1:0] elapsed_q, elapsed_d;
  logic [twc_pkg::BusyBits-1:0]    busy_q, busy_d;
  logic [twc_pkg::DelayBits-1:0]   delay;
  logic can_wake;

  assign delay    = word_i.charging ? cfg_i.charge_off_delay_ms : cfg_i.off_delay_ms;
  assign can_wake = asleep_q && cfg_i.wake_enable && !near_q && (busy_q == '0);

  always_comb begin
    touch_off_d = touch_off_q;
    hold_d      = hold_q;
    asleep_d    = asleep_q;
    timed_out_d = timed_out_q;
    near_d      = near_q;
    armed_d     = armed_q;
    off_timer_d = off_timer_q;
    off_run_d   = off_run_q;
    tap_timer_d = tap_timer_q;
    tap_run_d   = tap_run_q;
    elapsed_d   = elapsed_q;
    busy_d      = busy_q;
    unique case (word_i.cmd)
      twc_pkg::CMD_TICK: begin
        if (off_run_q) begin
          if (off_timer_q <= twc_pkg::DelayBits'(1)) begin
            off_timer_d = '0;
            off_run_d   = 1'b0;
            touch_off_d = 1'b1;
            hold_d      = 1'b0;
          end else begin
            off_timer_d = off_timer_q - twc_pkg::DelayBits'(1);
          end
        end
        if (tap_run_q) begin
          if (tap_timer_q <= twc_pkg::WindowBits'(1)) begin
            tap_timer_d = '0;
            tap_run_d   = 1'b0;
            armed_d     = 1'b0;
          end else begin
            tap_timer_d = tap_timer_q - twc_pkg::WindowBits'(1);
          end
        end
        if (elapsed_q != twc_pkg::ElapsedMax) begin
          elapsed_d = elapsed_q + twc_pkg::ElapsedBits'(1);
        end
        if (busy_q != '0) begin
          busy_d = busy_q - twc_pkg::BusyBits'(1);
        end
      end
      twc_pkg::CMD_SUSPEND: begin
        if (cfg_i.wake_enable && timed_out_q && !near_q) begin
          hold_d = 1'b1;
          if ((delay != '0) && !off_run_q) begin
            off_timer_d = delay;
            off_run_d   = 1'b1;
          end
        end else begin
          touch_off_d = 1'b1;
        end
        asleep_d = 1'b1;
      end
      twc_pkg::CMD_RESUME: begin
        off_timer_d = '0;
        off_run_d   = 1'b0;
        hold_d      = 1'b0;
        touch_off_d = 1'b0;
        timed_out_d = 1'b1;
        asleep_d    = 1'b0;
      end
      twc_pkg::CMD_TOUCH: begin
        if (cfg_i.knock_enable && !armed_q) begin
          armed_d = 1'b1;
          if (!tap_run_q) begin
            tap_timer_d = cfg_i.knock_window_ms;
            tap_run_d   = 1'b1;
          end
        end else begin
          // armed tap only consumed in knock mode
          if (cfg_i.knock_enable) begin
            armed_d = 1'b0;
          end
          if (can_wake) begin
            busy_d = twc_pkg::BusyLoad;
          end
        end
      end
      twc_pkg::CMD_KEY_PRESS: begin
        elapsed_d = '0;
        if (!cfg_i.key_power_mode) begin
          timed_out_d = 1'b0;
        end
      end
      twc_pkg::CMD_KEY_RELEASE: begin
        if ((elapsed_q > twc_pkg::LongPress) || asleep_q) begin
          timed_out_d = 1'b1;
        end
      end
      twc_pkg::CMD_PROX_NEAR: near_d = 1'b1;
      twc_pkg::CMD_PROX_FAR:  near_d = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    res_o.touch_on     = !touch_off_d;
    res_o.wake_hold    = hold_d;
    res_o.key_down     = busy_d > twc_pkg::KdLimit;
    res_o.wake_busy    = busy_d != '0;
    res_o.is_suspended = asleep_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_off_q <= 1'b0;
      hold_q      <= 1'b0;
      asleep_q    <= 1'b0;
      timed_out_q <= 1'b1;
      near_q      <= 1'b0;
      armed_q     <= 1'b0;
      off_timer_q <= '0;
      off_run_q   <= 1'b0;
      tap_timer_q <= '0;
      tap_run_q   <= 1'b0;
      elapsed_q   <= '0;
      busy_q      <= '0;
    end else if (step_i) begin
      touch_off_q <= touch_off_d;
      hold_q      <= hold_d;
      asleep_q    <= asleep_d;
      timed_out_q <= timed_out_d;
      near_q      <= near_d;
      armed_q     <= armed_d;
      off_timer_q <= off_timer_d;
      off_run_q   <= off_run_d;
      tap_timer_q <= tap_timer_d;
      tap_run_q   <= tap_run_d;
      elapsed_q   <= elapsed_d;
      busy_q      <= busy_d;
    end
  end

endmodule

[hw/rtl/touch_wake_controller.sv]
// ----------------------------------------------------------------------------
// touch_wake_controller
// touch wake control: suspend hold timer, knock detect, synthetic key press
//
//   channel  | direction | handshake           | word
//   in       | input     | in_valid/in_ready   | in_word_t (cmd, charging)
//   out      | output    | out_valid/out_ready | out_word_t (five status bits)
//   cfg      | input     | cfg_we              | cfg_idx, cfg_wdata
//
// one event word per cycle while out_ready keeps the result register free; the
// input register feeds the state update, which writes the result register
// twc_core updates its state on the same edge that writes the result register
// reset clears state, restores default register values, no clearing pass
// a stalled result holds the update stage, which then holds the input register
// ----------------------------------------------------------------------------
`include "touch_wake_controller_assert.svh"

module touch_wake_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  twc_pkg::in_word_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output twc_pkg::out_word_t                   out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [twc_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [twc_pkg::CfgDataBits-1:0]      cfg_wdata_i
);

  logic               in_valid_q;
  twc_pkg::in_word_t  in_data_q;
  logic               out_valid_q;
  twc_pkg::out_word_t out_data_q;
  twc_pkg::out_word_t res;
  twc_pkg::cfg_t      cfg_q;
  logic               advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  twc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .word_i (in_data_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wake_enable         <= 1'b0;
      cfg_q.key_power_mode      <= 1'b0;
      cfg_q.knock_enable        <= 1'b0;
      cfg_q.knock_window_ms     <= twc_pkg::WindowBits'(400);
      cfg_q.off_delay_ms        <= twc_pkg::DelayBits'(10000);
      cfg_q.charge_off_delay_ms <= twc_pkg::DelayBits'(60000);
    end else if (cfg_we_i) begin
      unique case (twc_pkg::cfg_idx_e'(cfg_idx_i))
        twc_pkg::CFG_WAKE_ENABLE:  cfg_q.wake_enable     <= cfg_wdata_i[0];
        twc_pkg::CFG_KEY_POWER:    cfg_q.key_power_mode  <= cfg_wdata_i[0];
        twc_pkg::CFG_KNOCK_ENABLE: cfg_q.knock_enable    <= cfg_wdata_i[0];
        twc_pkg::CFG_KNOCK_WINDOW: begin
          cfg_q.knock_window_ms <= cfg_wdata_i[twc_pkg::WindowBits-1:0];
        end
        twc_pkg::CFG_OFF_DELAY: begin
          cfg_q.off_delay_ms <= cfg_wdata_i[twc_pkg::DelayBits-1:0];
        end
        twc_pkg::CFG_CHARGE_DELAY: begin
          cfg_q.charge_off_delay_ms <= cfg_wdata_i[twc_pkg::DelayBits-1:0];
        end
        default: ;
      endcase
    end
  end

  `TWC_ASSERT(a_key_down_busy, out_valid_o && out_data_o.key_down |-> out_data_o.wake_busy)
  `TWC_ASSERT(a_hold_suspended, out_valid_o && out_data_o.wake_hold |-> out_data_o.is_suspended)
  `TWC_ASSERT(a_accept_fills, in_valid_i && in_ready_o |=> in_valid_q)
  `TWC_ASSERT_NEVER(a_no_lost_result, advance && out_valid_q && !out_ready_i)

endmodule
